[rtl/core/ray_triangle_closest_hit_macros.svh]
// Assertion macros used by the checker file of the ray/triangle closest-hit block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RAY_TRIANGLE_CLOSEST_HIT_MACROS_SVH
`define RAY_TRIANGLE_CLOSEST_HIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RTC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rtc_pkg.sv]
// Package of the ray/triangle closest-hit block: constants, word types, codes and helpers.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps

package rtc_pkg;

    localparam int DATA_W          = 32;
    localparam int FRAC_BITS       = 16;
    localparam int INDEX_WIDTH     = 16;
    localparam int EPS_W           = 16;
    localparam int CFG_INDEX_W     = 4;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int ACC_W           = 2 * DATA_W - FRAC_BITS + 2;
    localparam int DIV_W           = DATA_W + FRAC_BITS;

    typedef logic signed [DATA_W-1:0] fixed_t;
    typedef logic [2:0][DATA_W-1:0] vec3_t;

    localparam fixed_t ONE_FIXED     = DATA_W'(64'sd1 <<< FRAC_BITS);
    localparam fixed_t MISS_DISTANCE = -ONE_FIXED;
    localparam fixed_t FIXED_MAX     = {1'b0, {(DATA_W-1){1'b1}}};
    localparam fixed_t FIXED_MIN     = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        fixed_t                 v0_x;
        fixed_t                 v0_y;
        fixed_t                 v0_z;
        fixed_t                 v1_x;
        fixed_t                 v1_y;
        fixed_t                 v1_z;
        fixed_t                 v2_x;
        fixed_t                 v2_y;
        fixed_t                 v2_z;
        logic [INDEX_WIDTH-1:0] tri_index;
        logic                   last_tri;
    } item_t;

    typedef struct packed {
        logic                   hit;
        fixed_t                 hit_distance;
        logic [INDEX_WIDTH-1:0] hit_index;
    } result_t;

    typedef struct packed {
        vec3_t            origin;
        vec3_t            dir;
        logic [EPS_W-1:0] det_eps;
        logic [EPS_W-1:0] t_eps;
    } ray_cfg_t;

    typedef struct packed {
        vec3_t                  e1;
        vec3_t                  e2;
        vec3_t                  tv;
        logic [INDEX_WIDTH-1:0] index;
        logic                   last;
    } work_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ORG_X,
        REG_ORG_Y,
        REG_ORG_Z,
        REG_DIR_X,
        REG_DIR_Y,
        REG_DIR_Z,
        REG_DET_EPS,
        REG_T_EPS
    } cfg_reg_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_EMIT
    } eng_state_t;

    typedef enum logic [2:0] {
        GRP_P,
        GRP_DET,
        GRP_UN,
        GRP_Q,
        GRP_VN,
        GRP_TN
    } mul_grp_t;

    function automatic fixed_t sat_fixed(input logic signed [ACC_W-1:0] x);
        logic [ACC_W-DATA_W:0] upper;
        upper = x[ACC_W-1:DATA_W-1];
        if (upper == '0 || upper == '1)
        begin
            return x[DATA_W-1:0];
        end
        else if (x[ACC_W-1])
        begin
            return FIXED_MIN;
        end
        else
        begin
            return FIXED_MAX;
        end
    endfunction

    function automatic logic [1:0] next3(input logic [1:0] c);
        return (c == 2'd2) ? 2'd0 : c + 2'd1;
    endfunction

endpackage

[rtl/core/ray_triangle_closest_hit.sv]
// Each triangle word is taken from the queue, runs on the shared 32x32 multiplier that
// forms the cross and dot products, is drained and classified, and then updates the closest
// hit; a triangle that passes the barycentric tests first has t formed by the 48-step
// bit-serial divider. The word marked last then places the result word, and it waits while
// an earlier result word is still unread. A queue of QUEUE_DEPTH words in front of the
// engine takes new triangles while the engine works.
// Top level of the ray/triangle closest-hit block; depends on rtc_pkg, rtc_front, rtc_engine.
`timescale 1ns / 1ps

module ray_triangle_closest_hit #(
    parameter int QUEUE_DEPTH = rtc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rtc_pkg::item_t                  item,
    input  logic                            push,
    output logic                            full,
    output rtc_pkg::result_t                result,
    output logic                            empty,
    input  logic                            pop,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rtc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rtc_pkg::DATA_W-1:0]      cfg_data
);
    import rtc_pkg::*;

    ray_cfg_t cfg_reg;
    work_t    work;
    logic     work_valid;
    logic     work_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin  <= '0;
            cfg_reg.dir     <= {ONE_FIXED, {(2*DATA_W){1'b0}}};
            cfg_reg.det_eps <= EPS_W'(1);
            cfg_reg.t_eps   <= EPS_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ORG_X:   cfg_reg.origin[0] <= cfg_data;
                REG_ORG_Y:   cfg_reg.origin[1] <= cfg_data;
                REG_ORG_Z:   cfg_reg.origin[2] <= cfg_data;
                REG_DIR_X:   cfg_reg.dir[0] <= cfg_data;
                REG_DIR_Y:   cfg_reg.dir[1] <= cfg_data;
                REG_DIR_Z:   cfg_reg.dir[2] <= cfg_data;
                REG_DET_EPS: cfg_reg.det_eps <= cfg_data[EPS_W-1:0];
                REG_T_EPS:   cfg_reg.t_eps <= cfg_data[EPS_W-1:0];
                default:     ;
            endcase
        end
    end

    rtc_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push       (push),
        .full       (full),
        .origin     (cfg_reg.origin),
        .work       (work),
        .work_valid (work_valid),
        .work_pop   (work_pop)
    );

    rtc_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .work       (work),
        .work_valid (work_valid),
        .work_pop   (work_pop),
        .cfg        (cfg_reg),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

[rtl/core/rtc_front.sv]
// Front end: takes triangle words, forms the edge and origin vectors, and queues them.
// Depends on rtc_pkg.
`timescale 1ns / 1ps

module rtc_front #(
    parameter int DEPTH = rtc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rtc_pkg::item_t item,
    input  logic           push,
    output logic           full,
    input  rtc_pkg::vec3_t origin,
    output rtc_pkg::work_t work,
    output logic           work_valid,
    input  logic           work_pop
);
    import rtc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    work_t          mem [DEPTH];
    work_t          work_in;
    vec3_t          v0;
    vec3_t          v1;
    vec3_t          v2;
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign v0 = {item.v0_z, item.v0_y, item.v0_x};
    assign v1 = {item.v1_z, item.v1_y, item.v1_x};
    assign v2 = {item.v2_z, item.v2_y, item.v2_x};

    always_comb
    begin
        work_in.index = item.tri_index;
        work_in.last  = item.last_tri;
        for (int k = 0; k < 3; k++)
        begin
            work_in.e1[k] = sat_fixed(ACC_W'($signed(v1[k])) - ACC_W'($signed(v0[k])));
            work_in.e2[k] = sat_fixed(ACC_W'($signed(v2[k])) - ACC_W'($signed(v0[k])));
            work_in.tv[k] = sat_fixed(ACC_W'($signed(origin[k])) - ACC_W'($signed(v0[k])));
        end
    end

    assign full       = (count_reg == CW'(DEPTH));
    assign work_valid = (count_reg != '0);
    assign do_push    = push && !full;
    assign do_pop     = work_pop && work_valid;
    assign work       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= work_in;
        end
    end

endmodule

[rtl/core/rtc_engine.sv]
// Back end: one shared multiplier runs the cross and dot products, a bit-serial divider
// forms t, and the closest hit is tracked and reported. Depends on rtc_pkg.
`timescale 1ns / 1ps

module rtc_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  rtc_pkg::work_t   work,
    input  logic             work_valid,
    output logic             work_pop,
    input  rtc_pkg::ray_cfg_t cfg,
    output rtc_pkg::result_t result,
    output logic             empty,
    input  logic             pop
);
    import rtc_pkg::*;

    localparam int STEP_W    = 5;
    localparam int MUL_STEPS = 24;
    localparam int XW        = DATA_W + 1;
    localparam int DCW       = $clog2(DIV_W + 1);
    localparam logic [DIV_W-1:0] POS_LIM = DIV_W'({1'b0, {(DATA_W-1){1'b1}}});
    localparam logic [DIV_W-1:0] NEG_LIM = DIV_W'({1'b1, {(DATA_W-1){1'b0}}});

    eng_state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;
    logic mul_vld_reg, mul_vld_next;
    logic cand_reg, cand_next;
    logic have_hit_reg, have_hit_next;
    logic out_valid_reg, out_valid_next;

    work_t work_reg;
    result_t result_reg;
    vec3_t p_reg;
    vec3_t q_reg;
    fixed_t det_reg;
    fixed_t un_reg;
    fixed_t vn_reg;
    fixed_t tn_reg;
    fixed_t best_dist_reg;
    logic [INDEX_WIDTH-1:0] best_idx_reg;

    logic signed [2*DATA_W-1:0] prod_reg;
    logic neg_reg;
    logic first_reg;
    logic last_reg;
    mul_grp_t grp_reg;
    logic [1:0] comp_reg;
    logic signed [ACC_W-1:0] acc_reg;

    mul_grp_t grp;
    logic [2:0] k;
    logic is_cross;
    logic [1:0] comp;
    logic [1:0] ia;
    logic [1:0] ib;
    vec3_t vec_a;
    vec3_t vec_b;
    fixed_t op_a;
    fixed_t op_b;
    logic op_neg;
    logic op_first;
    logic op_last;

    logic signed [2*DATA_W-1:0] prod_sh;
    logic signed [ACC_W-1:0] sp;
    logic signed [ACC_W-1:0] acc_base;
    logic signed [ACC_W-1:0] acc_sum;
    fixed_t acc_sat;

    logic det_neg;
    logic signed [XW-1:0] det_p;
    logic signed [XW-1:0] un_p;
    logic signed [XW-1:0] vn_p;
    logic signed [XW-1:0] tn_p;
    logic signed [XW:0] uv_sum;
    logic signed [XW-1:0] tn_abs;
    logic reject;

    logic [DATA_W-1:0] det_mag_reg;
    logic tn_neg_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W:0] rem_shift;
    logic [DATA_W:0] rem_diff;
    logic div_ge;

    fixed_t t_val;
    fixed_t t_eps_x;
    logic take;

    always_comb
    begin
        grp = GRP_P;
        k   = '0;
        case (step_reg) inside
            [5'd0:5'd5]:
            begin
                grp = GRP_P;
                k   = step_reg[2:0];
            end
            [5'd6:5'd8]:
            begin
                grp = GRP_DET;
                k   = 3'(step_reg - 5'd6);
            end
            [5'd9:5'd11]:
            begin
                grp = GRP_UN;
                k   = 3'(step_reg - 5'd9);
            end
            [5'd12:5'd17]:
            begin
                grp = GRP_Q;
                k   = 3'(step_reg - 5'd12);
            end
            [5'd18:5'd20]:
            begin
                grp = GRP_VN;
                k   = 3'(step_reg - 5'd18);
            end
            default:
            begin
                grp = GRP_TN;
                k   = 3'(step_reg - 5'd21);
            end
        endcase
    end

    always_comb
    begin
        case (grp)
            GRP_P:
            begin
                vec_a = cfg.dir;
                vec_b = work_reg.e2;
            end
            GRP_DET:
            begin
                vec_a = work_reg.e1;
                vec_b = p_reg;
            end
            GRP_UN:
            begin
                vec_a = work_reg.tv;
                vec_b = p_reg;
            end
            GRP_Q:
            begin
                vec_a = work_reg.tv;
                vec_b = work_reg.e1;
            end
            GRP_VN:
            begin
                vec_a = cfg.dir;
                vec_b = q_reg;
            end
            default:
            begin
                vec_a = work_reg.e2;
                vec_b = q_reg;
            end
        endcase
    end

    // A cross component is a[c+1]*b[c+2] - a[c+2]*b[c+1], indices taken modulo three.
    assign is_cross = (grp == GRP_P) || (grp == GRP_Q);
    assign comp     = is_cross ? k[2:1] : 2'd0;
    assign ia       = is_cross ? (k[0] ? next3(next3(comp)) : next3(comp)) : k[1:0];
    assign ib       = is_cross ? (k[0] ? next3(comp) : next3(next3(comp))) : k[1:0];
    assign op_a     = vec_a[ia];
    assign op_b     = vec_b[ib];
    assign op_neg   = is_cross && k[0];
    assign op_first = is_cross ? !k[0] : (k == 3'd0);
    assign op_last  = is_cross ? k[0] : (k == 3'd2);

    assign prod_sh  = prod_reg >>> FRAC_BITS;
    assign sp       = $signed(prod_sh[ACC_W-1:0]);
    assign acc_base = first_reg ? ACC_W'(0) : acc_reg;
    assign acc_sum  = acc_base + (neg_reg ? -sp : sp);
    assign acc_sat  = sat_fixed(acc_sum);

    assign det_neg = det_reg[DATA_W-1];
    assign det_p   = det_neg ? -XW'(det_reg) : XW'(det_reg);
    assign un_p    = det_neg ? -XW'(un_reg) : XW'(un_reg);
    assign vn_p    = det_neg ? -XW'(vn_reg) : XW'(vn_reg);
    assign tn_p    = det_neg ? -XW'(tn_reg) : XW'(tn_reg);
    assign uv_sum  = (XW+1)'(un_p) + (XW+1)'(vn_p);
    assign tn_abs  = tn_p[XW-1] ? -tn_p : tn_p;
    assign reject  = (det_reg == '0)
                  || ($unsigned(det_p) < XW'(cfg.det_eps))
                  || un_p[XW-1] || (un_p > det_p)
                  || vn_p[XW-1] || (uv_sum > (XW+1)'(det_p));

    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_diff  = rem_shift - {1'b0, det_mag_reg};
    assign div_ge    = (rem_shift >= {1'b0, det_mag_reg});

    always_comb
    begin
        if (tn_neg_reg)
        begin
            t_val = (quo_reg > NEG_LIM) ? FIXED_MIN : -$signed(quo_reg[DATA_W-1:0]);
        end
        else
        begin
            t_val = (quo_reg > POS_LIM) ? FIXED_MAX : $signed(quo_reg[DATA_W-1:0]);
        end
    end

    assign t_eps_x = $signed({{(DATA_W-EPS_W){1'b0}}, cfg.t_eps});
    assign take    = cand_reg && (t_val > t_eps_x) && (!have_hit_reg || (t_val < best_dist_reg));

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        div_cnt_next   = div_cnt_reg;
        mul_vld_next   = (state_reg == ST_MUL);
        cand_next      = cand_reg;
        have_hit_next  = have_hit_reg;
        out_valid_next = out_valid_reg;
        work_pop       = 1'b0;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (work_valid)
                begin
                    work_pop   = 1'b1;
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cand_next    = 1'b0;
                div_cnt_next = '0;
                state_next   = reject ? ST_UPDATE : ST_DIV;
            end
            ST_DIV:
            begin
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DCW'(DIV_W - 1))
                begin
                    cand_next  = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                have_hit_next = have_hit_reg || take;
                state_next    = work_reg.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    have_hit_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            div_cnt_reg   <= '0;
            mul_vld_reg   <= 1'b0;
            cand_reg      <= 1'b0;
            have_hit_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            div_cnt_reg   <= div_cnt_next;
            mul_vld_reg   <= mul_vld_next;
            cand_reg      <= cand_next;
            have_hit_reg  <= have_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work_pop)
        begin
            work_reg <= work;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg  <= op_a * op_b;
            neg_reg   <= op_neg;
            first_reg <= op_first;
            last_reg  <= op_last;
            grp_reg   <= grp;
            comp_reg  <= comp;
        end
        if (mul_vld_reg)
        begin
            acc_reg <= acc_sum;
            if (last_reg)
            begin
                case (grp_reg)
                    GRP_P:   p_reg[comp_reg] <= acc_sat;
                    GRP_DET: det_reg <= acc_sat;
                    GRP_UN:  un_reg <= acc_sat;
                    GRP_Q:   q_reg[comp_reg] <= acc_sat;
                    GRP_VN:  vn_reg <= acc_sat;
                    default: tn_reg <= acc_sat;
                endcase
            end
        end
        if (state_reg == ST_CHECK)
        begin
            det_mag_reg <= det_p[DATA_W-1:0];
            tn_neg_reg  <= tn_p[XW-1];
            quo_reg     <= {tn_abs[DATA_W-1:0], {FRAC_BITS{1'b0}}};
            rem_reg     <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], div_ge};
            rem_reg <= div_ge ? rem_diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
        end
        if (state_reg == ST_UPDATE && take)
        begin
            best_dist_reg <= t_val;
            best_idx_reg  <= work_reg.index;
        end
        if (state_reg == ST_EMIT && !out_valid_reg)
        begin
            result_reg.hit          <= have_hit_reg;
            result_reg.hit_distance <= have_hit_reg ? best_dist_reg : MISS_DISTANCE;
            result_reg.hit_index    <= have_hit_reg ? best_idx_reg : '0;
        end
    end

    assign result = result_reg;
    assign empty  = !out_valid_reg;

endmodule

[rtl/core/rtc_checker.sv]
// Port-level checks on result words of the ray/triangle closest-hit block, bound to its top.
// Depends on rtc_pkg and ray_triangle_closest_hit_macros.svh.
`timescale 1ns / 1ps
`include "ray_triangle_closest_hit_macros.svh"

module rtc_checker (
    input logic             clk,
    input logic             rst_n,
    input rtc_pkg::result_t result,
    input logic             empty,
    input logic             pop
);
    import rtc_pkg::*;

    logic word_miss;
    logic word_hit;
    logic miss_form_ok;
    logic hit_ahead_ok;
    logic word_held;

    assign word_miss    = !empty && !result.hit;
    assign word_hit     = !empty && result.hit;
    assign miss_form_ok = (result.hit_distance == MISS_DISTANCE) && (result.hit_index == '0);
    assign hit_ahead_ok = !result.hit_distance[DATA_W-1] && (result.hit_distance != '0);
    assign word_held    = !empty && !pop;

    // A miss word always carries the fixed miss distance and a zero index.
    `RTC_ASSERT_SAME(a_miss_form, word_miss, miss_form_ok, "miss word not in canonical form")

    // An accepted hit lies strictly in front of the origin.
    `RTC_ASSERT_SAME(a_hit_ahead, word_hit, hit_ahead_ok, "hit distance not positive")

    `RTC_ASSERT_NEXT(a_result_hold, word_held, !empty && $stable(result), "result word changed")

endmodule

bind ray_triangle_closest_hit rtc_checker u_rtc_checker (.*);
